// File: hw/rtl/spring_damper_torque_core_macros.svh
// ----------------------------------------------------------------------------
// spring_damper_torque_core_macros
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef SPRING_DAMPER_TORQUE_CORE_MACROS_SVH
`define SPRING_DAMPER_TORQUE_CORE_MACROS_SVH

// property sampled on clk, off while arst_n is low
`define SPDT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition in this cycle implies consequence in the next one
`define SPDT_ASSERT_NEXT(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/spdt_pkg.sv
// ----------------------------------------------------------------------------
// spdt_pkg
// Types, constants and helpers of the spring/damper torque core.
// ----------------------------------------------------------------------------
package spdt_pkg;

	localparam int TABLE_POINTS_DEF = 16;
	localparam int DIV_STAGES       = 32;

	// configuration register indexes
	localparam logic [2:0] CFG_SPRING_GAIN  = 3'd0;
	localparam logic [2:0] CFG_REST_ANGLE   = 3'd1;
	localparam logic [2:0] CFG_DAMPING_GAIN = 3'd2;
	localparam logic [2:0] CFG_TORQUE_LIMIT = 3'd3;
	localparam logic [2:0] CFG_LIMIT_ENABLE = 3'd4;
	localparam logic [2:0] CFG_CURVE_POINTS = 3'd5;

	// input item kinds
	localparam logic KIND_EVAL = 1'b0;
	localparam logic KIND_LOAD = 1'b1;

	// how the spring torque is formed
	typedef enum logic [1:0] {
		MODE_HOOKE,
		MODE_LOW,
		MODE_HIGH,
		MODE_INTERP
	} mode_t;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] angle;
		logic signed [31:0] velocity;
		logic [3:0]         point_index;
		logic signed [31:0] point_angle;
		logic signed [31:0] point_torque;
	} in_item_t;

	// result of the table lookup stages
	typedef struct packed {
		logic signed [31:0] angle;
		logic signed [31:0] velocity;
		mode_t              mode;
		logic signed [31:0] a_lo;
		logic signed [31:0] a_hi;
		logic signed [31:0] t_lo;
		logic signed [31:0] t_hi;
	} lk_out_t;

	// side data riding along the divider
	typedef struct packed {
		logic               hook;
		logic               neg;
		logic signed [31:0] t_lo;
		logic signed [48:0] h;
		logic signed [47:0] dm;
	} pay_t;

	typedef struct packed {
		logic [31:0] rem;
		logic [31:0] dvd;
		logic [31:0] dvs;
		logic [31:0] quo;
		pay_t        pay;
	} div_stage_t;

	// one restoring division step, one quotient bit
	function automatic div_stage_t div_step(div_stage_t s);
		div_stage_t r;
		logic [32:0] t;
		logic        ge;
		r  = s;
		t  = {s.rem, s.dvd[31]};
		ge = (t >= {1'b0, s.dvs});
		r.rem = ge ? 32'(t - {1'b0, s.dvs}) : t[31:0];
		r.dvd = {s.dvd[30:0], 1'b0};
		r.quo = {s.quo[30:0], ge};
		return r;
	endfunction

endpackage

// File: hw/rtl/spdt_ifs.sv
// ----------------------------------------------------------------------------
// spdt_ifs
// Valid/ready channels of the torque core.
// ----------------------------------------------------------------------------
interface spdt_in_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic signed [31:0] angle;
	logic signed [31:0] velocity;
	logic [3:0]         point_index;
	logic signed [31:0] point_angle;
	logic signed [31:0] point_torque;
	modport source(output valid, kind, angle, velocity, point_index, point_angle,
		point_torque, input ready);
	modport sink(input valid, kind, angle, velocity, point_index, point_angle,
		point_torque, output ready);
endinterface

interface spdt_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] torque;
	logic               saturated;
	modport source(output valid, torque, saturated, input ready);
	modport sink(input valid, torque, saturated, output ready);
endinterface

// File: hw/rtl/spdt_lookup.sv
// ----------------------------------------------------------------------------
// spdt_lookup
// Breakpoint tables, bracket search and operand fetch (stages s1..s3).
// ----------------------------------------------------------------------------
module spdt_lookup #(
	parameter int TABLE_POINTS = spdt_pkg::TABLE_POINTS_DEF,
	parameter int IDX_W        = $clog2(TABLE_POINTS),
	parameter int N_W          = $clog2(TABLE_POINTS + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_v,
	input  spdt_pkg::in_item_t in_item,
	input  logic [N_W-1:0]     n_pts,
	output logic               v_s3,
	output spdt_pkg::lk_out_t  out_s3
);

	// stage 1
	logic               v_s1;
	spdt_pkg::in_item_t it_s1;
	// stage 2
	logic               v_s2;
	spdt_pkg::in_item_t it_s2;
	spdt_pkg::mode_t    mode_s2;
	logic [IDX_W-1:0]   lo_s2;
	logic [IDX_W-1:0]   hi_s2;

	// compare copy of the angle table: each entry read at its own comparator
	logic signed [31:0] atab_q [TABLE_POINTS];
	// indexed copies
	logic signed [31:0] ang_mem [TABLE_POINTS];
	logic signed [31:0] trq_mem [TABLE_POINTS];

	logic [TABLE_POINTS-1:0] gt;
	logic [TABLE_POINTS-1:0] ge;
	logic [IDX_W-1:0]        last;
	logic [IDX_W-1:0]        hi_c;
	logic [IDX_W-1:0]        lo_c;
	spdt_pkg::mode_t         mode_c;
	logic                    ld_ok_s1;
	logic                    ld_ok_s2;
	logic [IDX_W-1:0]        widx_s1;
	logic [IDX_W-1:0]        widx_s2;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && (it_s2.kind == spdt_pkg::KIND_EVAL);
		end
	end

	// load slot decode
	assign ld_ok_s1 = v_s1 && (it_s1.kind == spdt_pkg::KIND_LOAD)
		&& (32'(it_s1.point_index) < TABLE_POINTS);
	assign ld_ok_s2 = v_s2 && (it_s2.kind == spdt_pkg::KIND_LOAD)
		&& (32'(it_s2.point_index) < TABLE_POINTS);
	assign widx_s1 = IDX_W'(it_s1.point_index);
	assign widx_s2 = IDX_W'(it_s2.point_index);

	// bracket search against every breakpoint
	always_comb begin
		for (int i = 0; i < TABLE_POINTS; i++) begin
			gt[i] = atab_q[i] > it_s1.angle;
			ge[i] = it_s1.angle >= atab_q[i];
		end
		last = IDX_W'(n_pts - 1'b1);
		hi_c = last;
		for (int i = TABLE_POINTS - 1; i >= 1; i--) begin
			if ((IDX_W'(i) <= last) && gt[i]) begin
				hi_c = IDX_W'(i);
			end
		end
		if (32'(n_pts) < 2) begin
			mode_c = spdt_pkg::MODE_HOOKE;
			lo_c   = '0;
		end else if (!gt[0]) begin
			mode_c = (it_s1.angle == atab_q[0]) ? spdt_pkg::MODE_LOW : spdt_pkg::MODE_INTERP;
			lo_c   = '0;
			if (ge[last]) begin
				mode_c = spdt_pkg::MODE_HIGH;
				lo_c   = last;
			end
			if (it_s1.angle == atab_q[0]) begin
				mode_c = spdt_pkg::MODE_LOW;
				lo_c   = '0;
			end else if (!ge[last]) begin
				lo_c = hi_c - 1'b1;
			end
		end else begin
			mode_c = spdt_pkg::MODE_LOW;
			lo_c   = '0;
		end
	end

	// compare table written as a load leaves s1
	always_ff @(posedge clk) begin
		if (en && ld_ok_s1) begin
			atab_q[widx_s1] <= it_s1.point_angle;
		end
	end

	// stage payload; indexed tables written as a load leaves s2, read into s3
	always_ff @(posedge clk) begin
		if (en) begin
			it_s1   <= in_item;
			it_s2   <= it_s1;
			mode_s2 <= mode_c;
			lo_s2   <= lo_c;
			hi_s2   <= hi_c;
			out_s3.angle    <= it_s2.angle;
			out_s3.velocity <= it_s2.velocity;
			out_s3.mode     <= mode_s2;
			if (ld_ok_s2) begin
				ang_mem[widx_s2] <= it_s2.point_angle;
				trq_mem[widx_s2] <= it_s2.point_torque;
			end
			out_s3.a_lo <= ang_mem[lo_s2];
			out_s3.a_hi <= ang_mem[hi_s2];
			out_s3.t_lo <= trq_mem[lo_s2];
			out_s3.t_hi <= trq_mem[hi_s2];
		end
	end

endmodule

// File: hw/rtl/spdt_div.sv
// ----------------------------------------------------------------------------
// spdt_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module spdt_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 v_in,
	input  spdt_pkg::div_stage_t d_in,
	output logic                 v_out,
	output spdt_pkg::div_stage_t d_out
);

	localparam int N = spdt_pkg::DIV_STAGES;

	logic                 v_q  [N];
	spdt_pkg::div_stage_t st_q [N];

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) begin
				v_q[k] <= 1'b0;
			end
		end else if (en) begin
			v_q[0] <= v_in;
			for (int k = 1; k < N; k++) begin
				v_q[k] <= v_q[k-1];
			end
		end
	end

	// one step per stage
	always_ff @(posedge clk) begin
		if (en) begin
			st_q[0] <= spdt_pkg::div_step(d_in);
			for (int k = 1; k < N; k++) begin
				st_q[k] <= spdt_pkg::div_step(st_q[k-1]);
			end
		end
	end

	assign v_out = v_q[N-1];
	assign d_out = st_q[N-1];

endmodule

// File: hw/rtl/spring_damper_torque_core.sv
// ----------------------------------------------------------------------------
// spring_damper_torque_core
// Piecewise-linear or linear spring torque minus viscous damping, Q16.16.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in_ch   | in  | kind, angle, velocity, point_index, point_angle, point_torque
//  out_ch  | out | torque, saturated
//  cfg     | in  | cfg_we, cfg_idx, cfg_data (write only)
//
//  39-stage pipeline: 3 lookup, 2 multiply, 32 divider (one quotient bit
//  each), 1 finish, 1 output register. One item per cycle while the output
//  is not stalled.
//  Load items update the tables in flight and produce no transaction.
//  A stalled output freezes every stage; nothing is dropped or repeated.
//  Reset clears valid bits and configuration; tables hold garbage until loaded.
// ----------------------------------------------------------------------------
module spring_damper_torque_core #(
	parameter int TABLE_POINTS = spdt_pkg::TABLE_POINTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	spdt_in_if.sink     in_ch,
	spdt_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_data
);

	localparam int IDX_W = $clog2(TABLE_POINTS);
	localparam int N_W   = $clog2(TABLE_POINTS + 1);

	// configuration
	logic signed [31:0] gain_q;
	logic signed [31:0] rest_q;
	logic signed [31:0] damp_q;
	logic [30:0]        lim_q;
	logic               lim_en_q;
	logic [4:0]         pts_q;
	logic [N_W-1:0]     n_pts;

	logic               en;
	spdt_pkg::in_item_t in_item;
	logic               v_s3;
	spdt_pkg::lk_out_t  lk_s3;

	// stage 4
	logic               v_s4;
	logic               hook_s4;
	logic               neg_s4;
	logic signed [31:0] tlo_s4;
	logic signed [32:0] diff_s4;
	logic signed [47:0] dm_s4;
	logic [31:0]        dmag_s4;
	logic [31:0]        dtmag_s4;
	logic [31:0]        span_s4;
	// stage 5
	logic               v_s5;
	spdt_pkg::div_stage_t dv_s5;
	// finish stages
	logic               v_div;
	spdt_pkg::div_stage_t dv_out;
	logic               v_s6;
	logic signed [50:0] tau_s6;
	logic               v_out_q;
	logic signed [31:0] trq_q;
	logic               sat_q;

	logic signed [32:0] span_c;
	logic signed [32:0] d_c;
	logic signed [32:0] dt_c;
	logic signed [32:0] dcl_c;
	logic signed [32:0] dtm_c;
	logic signed [63:0] dprod_c;
	logic signed [64:0] hprod_c;
	logic [63:0]        tprod_c;
	logic signed [49:0] spring_c;
	logic signed [50:0] lim_c;
	logic signed [50:0] clip_c;
	logic signed [31:0] res_c;

	// handshake: all stages move together
	assign en          = !v_out_q || out_ch.ready;
	assign in_ch.ready = en;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= '0;
			rest_q   <= '0;
			damp_q   <= '0;
			lim_q    <= '0;
			lim_en_q <= 1'b0;
			pts_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				spdt_pkg::CFG_SPRING_GAIN:  gain_q   <= cfg_data;
				spdt_pkg::CFG_REST_ANGLE:   rest_q   <= cfg_data;
				spdt_pkg::CFG_DAMPING_GAIN: damp_q   <= cfg_data;
				spdt_pkg::CFG_TORQUE_LIMIT: lim_q    <= cfg_data[30:0];
				spdt_pkg::CFG_LIMIT_ENABLE: lim_en_q <= cfg_data[0];
				spdt_pkg::CFG_CURVE_POINTS: pts_q    <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// points in use, capped at the table size
	assign n_pts = (32'(pts_q) > TABLE_POINTS) ? N_W'(TABLE_POINTS) : N_W'(pts_q);

	assign in_item.kind         = in_ch.kind;
	assign in_item.angle        = in_ch.angle;
	assign in_item.velocity     = in_ch.velocity;
	assign in_item.point_index  = in_ch.point_index;
	assign in_item.point_angle  = in_ch.point_angle;
	assign in_item.point_torque = in_ch.point_torque;

	spdt_lookup #(
		.TABLE_POINTS(TABLE_POINTS),
		.IDX_W       (IDX_W),
		.N_W         (N_W)
	) u_lookup (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (in_ch.valid),
		.in_item(in_item),
		.n_pts  (n_pts),
		.v_s3   (v_s3),
		.out_s3 (lk_s3)
	);

	// segment operands and damping product
	always_comb begin
		span_c  = 33'(lk_s3.a_hi) - 33'(lk_s3.a_lo);
		d_c     = 33'(lk_s3.angle) - 33'(lk_s3.a_lo);
		dt_c    = 33'(lk_s3.t_hi) - 33'(lk_s3.t_lo);
		dtm_c   = (dt_c < 0) ? -dt_c : dt_c;
		dcl_c   = (d_c < 0) ? 33'sd0 : ((d_c > span_c) ? span_c : d_c);
		dprod_c = 64'(damp_q) * 64'(lk_s3.velocity);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_div;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hook_s4  <= (lk_s3.mode == spdt_pkg::MODE_HOOKE);
			neg_s4   <= dt_c < 0;
			tlo_s4   <= lk_s3.t_lo;
			diff_s4  <= 33'(rest_q) - 33'(lk_s3.angle);
			dm_s4    <= dprod_c[63:16];
			dtmag_s4 <= dtm_c[31:0];
			if ((lk_s3.mode == spdt_pkg::MODE_INTERP) && (span_c > 0)) begin
				dmag_s4 <= dcl_c[31:0];
				span_s4 <= span_c[31:0];
			end else begin
				dmag_s4 <= '0;
				span_s4 <= 32'd1;
			end
		end
	end

	// spring product and interpolation numerator
	assign hprod_c = 65'(gain_q) * 65'(diff_s4);
	assign tprod_c = 64'(dmag_s4) * 64'(dtmag_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s5.rem      <= tprod_c[63:32];
			dv_s5.dvd      <= tprod_c[31:0];
			dv_s5.dvs      <= span_s4;
			dv_s5.quo      <= '0;
			dv_s5.pay.hook <= hook_s4;
			dv_s5.pay.neg  <= neg_s4;
			dv_s5.pay.t_lo <= tlo_s4;
			dv_s5.pay.h    <= hprod_c[64:16];
			dv_s5.pay.dm   <= dm_s4;
		end
	end

	spdt_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.v_in  (v_s5),
		.d_in  (dv_s5),
		.v_out (v_div),
		.d_out (dv_out)
	);

	// spring torque minus damping
	always_comb begin
		if (dv_out.pay.hook) begin
			spring_c = 50'(dv_out.pay.h);
		end else if (dv_out.pay.neg) begin
			spring_c = 50'(dv_out.pay.t_lo) - $signed({18'd0, dv_out.quo});
		end else begin
			spring_c = 50'(dv_out.pay.t_lo) + $signed({18'd0, dv_out.quo});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tau_s6 <= 51'(spring_c) - 51'(dv_out.pay.dm);
		end
	end

	// torque limit, then 32-bit saturation
	always_comb begin
		lim_c  = $signed({20'd0, lim_q});
		clip_c = tau_s6;
		if (lim_en_q) begin
			if (tau_s6 > lim_c) begin
				clip_c = lim_c;
			end else if (tau_s6 < -lim_c) begin
				clip_c = -lim_c;
			end
		end
		if (clip_c > 51'sd2147483647) begin
			res_c = 32'sh7fffffff;
		end else if (clip_c < -51'sd2147483648) begin
			res_c = 32'sh80000000;
		end else begin
			res_c = clip_c[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out_q <= 1'b0;
		end else if (en) begin
			v_out_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			trq_q <= res_c;
			sat_q <= 51'(res_c) != tau_s6;
		end
	end

	assign out_ch.valid     = v_out_q;
	assign out_ch.torque    = trq_q;
	assign out_ch.saturated = sat_q;

endmodule

// File: hw/rtl/spdt_checker.sv
// ----------------------------------------------------------------------------
// spdt_checker
// Port-level checks of the torque core, bound to the top level.
// ----------------------------------------------------------------------------
`include "spring_damper_torque_core_macros.svh"

module spdt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_torque,
	input logic        out_saturated
);

	// input is taken exactly when the pipeline can move
	`SPDT_ASSERT(a_ready_follows_out, in_ready == (!out_valid || out_ready), "in ready mismatch")

	// a stalled result holds
	`SPDT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_torque) && $stable(out_saturated), "result changed under stall")

	// pipeline is empty right after reset
	`SPDT_ASSERT(a_empty_after_reset, !$past(arst_n) |-> !out_valid, "result right after reset")

endmodule

bind spring_damper_torque_core spdt_checker u_spdt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.out_torque   (out_ch.torque),
	.out_saturated(out_ch.saturated)
);
